FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the speed loop.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define VIPL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("speed loop check failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define VIPL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("speed loop check failed");

`endif

FILE: rtl/vipl_pkg.sv
// Package with the shared types and constants of the speed loop.
`default_nettype none
package vipl_pkg;

  localparam int CFG_IDX_W      = 3;
  localparam int PERIOD_BITS    = 32;
  localparam int ACCEL_MAX_INT  = 5;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_FF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BACKCALC = 3'd7;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_HOLD, S_STEP_GO, S_STEP_WT, S_CLAMP, S_DIV_GO, S_DIV_WT,
    S_AFF_GO, S_AFF_WT, S_VFF_GO, S_VFF_WT, S_FF, S_BT_GO, S_BT_WT, S_EW,
    S_P_GO, S_P_WT, S_KIE_GO, S_KIE_WT, S_I_GO, S_I_WT, S_SUM, S_GATE, S_LIMD,
    S_BCG_GO, S_BCG_WT, S_BCT_GO, S_BCT_WT, S_FINAL, S_PUSH
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_HOLD, OP_STEP, OP_CLAMP, OP_DIV, OP_AFF, OP_VFF, OP_FF, OP_BT,
    OP_EW, OP_P, OP_KIE, OP_I, OP_SUM, OP_GATE, OP_LIMD, OP_BCG, OP_BCT, OP_FINAL
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load;
    logic mul_go;
    logic div_go;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic per_zero;
    logic mul_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/vipl_mul.sv
// Sequential fixed-point multiplier, eight multiplier bits per cycle, saturating.
`default_nettype none
module vipl_mul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int MW         = (DATA_WIDTH > 32) ? DATA_WIDTH : 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [DATA_WIDTH-1:0] a_i,
  input  wire logic signed [MW:0]           b_i,
  input  wire logic                         sh32_i,
  output logic                              done_o,
  output logic signed [DATA_WIDTH-1:0]      res_o
);
  import vipl_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int NDIG = (MW + 7) / 8;
  localparam int BW   = NDIG * 8;
  localparam int PW   = DW + BW;
  localparam int CW   = $clog2(NDIG + 1);

  logic          busy_q, fin_q, neg_q, sh32_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] amag_q;
  logic [BW-1:0] bmag_q;
  logic [PW-1:0] acc_q;
  logic [DW-1:0] amag_d;
  logic [MW:0]   bneg;
  logic [PW-1:0] r, lim, rc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NDIG - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  assign amag_d = a_i[DW-1] ? DW'(-a_i) : DW'(a_i);
  assign bneg   = b_i[MW] ? (MW+1)'(-b_i) : (MW+1)'(b_i);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= a_i[DW-1] ^ b_i[MW];
      sh32_q <= sh32_i;
      amag_q <= amag_d;
      bmag_q <= BW'(bneg[MW-1:0]);
      acc_q  <= '0;
    end else if (busy_q) begin
      acc_q  <= (acc_q << 8) + PW'(amag_q * bmag_q[BW-1 -: 8]);
      bmag_q <= bmag_q << 8;
    end
  end

  always_comb begin
    r   = sh32_q ? (acc_q >> PERIOD_BITS) : (acc_q >> FRAC_BITS);
    lim = neg_q ? (PW'(1) << (DW - 1)) : ((PW'(1) << (DW - 1)) - PW'(1));
    rc  = (r > lim) ? lim : r;
    res_o = neg_q ? $signed(-rc[DW-1:0]) : $signed(rc[DW-1:0]);
  end

  assign done_o = fin_q;

endmodule
`default_nettype wire

FILE: rtl/vipl_div.sv
// Restoring divider for the acceleration, one quotient bit per cycle.
`default_nettype none
module vipl_div #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [DATA_WIDTH-1:0]        mag_i,
  input  wire logic                         neg_i,
  input  wire logic [31:0]                  per_i,
  output logic                              done_o,
  output logic signed [DATA_WIDTH-1:0]      res_o
);
  import vipl_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int NW = DW + PERIOD_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy_q, fin_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   rem_q, per_q;
  logic [NW-1:0] quo_q;
  logic [32:0]   rem2, diff;
  logic          ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  assign rem2 = {rem_q, quo_q[NW-1]};
  assign diff = rem2 - {1'b0, per_q};
  assign ge   = (rem2 >= {1'b0, per_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= neg_i;
      per_q <= per_i;
      rem_q <= '0;
      quo_q <= {mag_i, {PERIOD_BITS{1'b0}}};
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : rem2[31:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign res_o  = neg_q ? $signed(-quo_q[DW-1:0]) : $signed(quo_q[DW-1:0]);
  assign done_o = fin_q;

endmodule
`default_nettype wire

FILE: rtl/vipl_ctrl.sv
// Controller state machine that sequences one tick through the datapath.
`default_nettype none
module vipl_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire vipl_pkg::sts_t sts_i,
  output vipl_pkg::cmd_t      cmd_o
);
  import vipl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_START;
      S_START:   state_d = sts_i.per_zero ? S_HOLD : S_STEP_GO;
      S_HOLD:    state_d = S_PUSH;
      S_STEP_GO: state_d = S_STEP_WT;
      S_STEP_WT: if (sts_i.mul_done) state_d = S_CLAMP;
      S_CLAMP:   state_d = S_DIV_GO;
      S_DIV_GO:  state_d = S_DIV_WT;
      S_DIV_WT:  if (sts_i.div_done) state_d = S_AFF_GO;
      S_AFF_GO:  state_d = S_AFF_WT;
      S_AFF_WT:  if (sts_i.mul_done) state_d = S_VFF_GO;
      S_VFF_GO:  state_d = S_VFF_WT;
      S_VFF_WT:  if (sts_i.mul_done) state_d = S_FF;
      S_FF:      state_d = S_BT_GO;
      S_BT_GO:   state_d = S_BT_WT;
      S_BT_WT:   if (sts_i.mul_done) state_d = S_EW;
      S_EW:      state_d = S_P_GO;
      S_P_GO:    state_d = S_P_WT;
      S_P_WT:    if (sts_i.mul_done) state_d = S_KIE_GO;
      S_KIE_GO:  state_d = S_KIE_WT;
      S_KIE_WT:  if (sts_i.mul_done) state_d = S_I_GO;
      S_I_GO:    state_d = S_I_WT;
      S_I_WT:    if (sts_i.mul_done) state_d = S_SUM;
      S_SUM:     state_d = S_GATE;
      S_GATE:    state_d = S_LIMD;
      S_LIMD:    state_d = S_BCG_GO;
      S_BCG_GO:  state_d = S_BCG_WT;
      S_BCG_WT:  if (sts_i.mul_done) state_d = S_BCT_GO;
      S_BCT_GO:  state_d = S_BCT_WT;
      S_BCT_WT:  if (sts_i.mul_done) state_d = S_FINAL;
      S_FINAL:   state_d = S_PUSH;
      S_PUSH:    if (sts_i.out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_START:   cmd_o.op = OP_NONE;
      S_HOLD:    cmd_o.op = OP_HOLD;
      S_STEP_GO: begin cmd_o.op = OP_STEP; cmd_o.mul_go = 1'b1; end
      S_STEP_WT: cmd_o.op = OP_STEP;
      S_CLAMP:   cmd_o.op = OP_CLAMP;
      S_DIV_GO:  begin cmd_o.op = OP_DIV; cmd_o.div_go = 1'b1; end
      S_DIV_WT:  cmd_o.op = OP_DIV;
      S_AFF_GO:  begin cmd_o.op = OP_AFF; cmd_o.mul_go = 1'b1; end
      S_AFF_WT:  cmd_o.op = OP_AFF;
      S_VFF_GO:  begin cmd_o.op = OP_VFF; cmd_o.mul_go = 1'b1; end
      S_VFF_WT:  cmd_o.op = OP_VFF;
      S_FF:      cmd_o.op = OP_FF;
      S_BT_GO:   begin cmd_o.op = OP_BT; cmd_o.mul_go = 1'b1; end
      S_BT_WT:   cmd_o.op = OP_BT;
      S_EW:      cmd_o.op = OP_EW;
      S_P_GO:    begin cmd_o.op = OP_P; cmd_o.mul_go = 1'b1; end
      S_P_WT:    cmd_o.op = OP_P;
      S_KIE_GO:  begin cmd_o.op = OP_KIE; cmd_o.mul_go = 1'b1; end
      S_KIE_WT:  cmd_o.op = OP_KIE;
      S_I_GO:    begin cmd_o.op = OP_I; cmd_o.mul_go = 1'b1; end
      S_I_WT:    cmd_o.op = OP_I;
      S_SUM:     cmd_o.op = OP_SUM;
      S_GATE:    cmd_o.op = OP_GATE;
      S_LIMD:    cmd_o.op = OP_LIMD;
      S_BCG_GO:  begin cmd_o.op = OP_BCG; cmd_o.mul_go = 1'b1; end
      S_BCG_WT:  cmd_o.op = OP_BCG;
      S_BCT_GO:  begin cmd_o.op = OP_BCT; cmd_o.mul_go = 1'b1; end
      S_BCT_WT:  cmd_o.op = OP_BCT;
      S_FINAL:   cmd_o.op = OP_FINAL;
      S_PUSH:    cmd_o.push = sts_i.out_free;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/vipl_datapath.sv
// Datapath: configuration, loop state, working registers and the result register.
`default_nettype none
module vipl_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [vipl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [DATA_WIDTH-1:0]                cfg_data_i,
  input  wire logic signed [DATA_WIDTH-1:0]         speed_target_i,
  input  wire logic signed [DATA_WIDTH-1:0]         speed_measured_i,
  input  wire logic [vipl_pkg::PERIOD_BITS-1:0]     step_period_i,
  input  wire vipl_pkg::cmd_t                       cmd_i,
  output vipl_pkg::sts_t                            sts_o,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output logic signed [DATA_WIDTH-1:0]              torque_out_o,
  output logic signed [DATA_WIDTH-1:0]              feedforward_part_o,
  output logic signed [DATA_WIDTH-1:0]              feedback_part_o,
  output logic                                      integral_frozen_o,
  output logic                                      held_o
);
  import vipl_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int GW = DW - 1;
  localparam int MW = (DW > 32) ? DW : 32;
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] STEP_RATE = DW'(ACCEL_MAX_INT) << FRAC_BITS;
  localparam logic [GW-1:0] ONE_Q = GW'(1) << FRAC_BITS;

  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
    return s[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
    return s[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] clamp_l(input logic signed [DW-1:0] x,
                                                   input logic [GW-1:0] l);
    logic signed [DW-1:0] lp;
    lp = $signed({1'b0, l});
    if (x > lp) return lp;
    if (x < -lp) return -lp;
    return x;
  endfunction

  function automatic logic signed [MW:0] sext(input logic signed [DW-1:0] x);
    return $signed({{(MW+1-DW){x[DW-1]}}, x});
  endfunction

  // Configuration and loop state.
  logic [GW-1:0]        k_aff_q, k_vff_q, k_p_q, k_i_q, lim_q, beta_q, k_bc_q;
  logic signed [DW-1:0] fric_q;
  logic signed [DW-1:0] traj_q, pew_q, acc_q, last_q;
  logic                 out_valid_q;

  // Per-tick working registers.
  logic signed [DW-1:0] tgt_q, meas_q, stepmax_q, d_q, accel_q, aff_q, vff_q, ff_q;
  logic signed [DW-1:0] e_q, bt_q, ew_q, p_q, kie_q, i_q, ap_q, fbr_q, u_q;
  logic signed [DW-1:0] bcd_q, bc_q, t_q;
  logic [PERIOD_BITS-1:0] per_q;
  logic                 frozen_q, held_q;
  logic signed [DW-1:0] torque_q, ffo_q, fbo_q;
  logic                 frzo_q, heldo_q;

  // Arithmetic units.
  logic signed [DW-1:0] mul_a;
  logic signed [MW:0]   mul_b;
  logic                 mul_sh32, mul_done, div_done;
  logic signed [DW-1:0] mul_res, div_res;

  logic signed [DW:0]   diff, smx;
  logic signed [DW-1:0] d_next, u_raw, u_alt, acc_new, lp;
  logic                 sat_hit, same_dir, frz;
  logic signed [MW:0]   per_b;

  assign per_b = $signed({{(MW+1-PERIOD_BITS){1'b0}}, per_q});

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_sh32 = 1'b0;
    case (cmd_i.op)
      OP_STEP: begin mul_a = $signed(STEP_RATE); mul_b = per_b; mul_sh32 = 1'b1; end
      OP_AFF:  begin mul_a = $signed({1'b0, k_aff_q}); mul_b = sext(accel_q); end
      OP_VFF:  begin mul_a = $signed({1'b0, k_vff_q}); mul_b = sext(tgt_q); end
      OP_BT:   begin mul_a = $signed({1'b0, beta_q}); mul_b = sext(tgt_q); end
      OP_P:    begin mul_a = $signed({1'b0, k_p_q}); mul_b = sext(sat_sub(ew_q, pew_q)); end
      OP_KIE:  begin mul_a = $signed({1'b0, k_i_q}); mul_b = sext(e_q); end
      OP_I:    begin mul_a = kie_q; mul_b = per_b; mul_sh32 = 1'b1; end
      OP_BCG:  begin mul_a = $signed({1'b0, k_bc_q}); mul_b = sext(bcd_q); end
      OP_BCT:  begin mul_a = bc_q; mul_b = per_b; mul_sh32 = 1'b1; end
      default: begin mul_a = '0; mul_b = '0; mul_sh32 = 1'b0; end
    endcase
  end

  vipl_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .MW         (MW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sh32_i  (mul_sh32),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  vipl_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .mag_i   (d_q[DW-1] ? DW'(-d_q) : DW'(d_q)),
    .neg_i   (d_q[DW-1]),
    .per_i   (per_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_comb begin
    diff = {tgt_q[DW-1], tgt_q} - {traj_q[DW-1], traj_q};
    smx  = {stepmax_q[DW-1], stepmax_q};
    if (diff > smx) d_next = stepmax_q;
    else if (diff < -smx) d_next = -stepmax_q;
    else d_next = diff[DW-1:0];

    lp       = $signed({1'b0, lim_q});
    u_raw    = sat_add(ff_q, fbr_q);
    u_alt    = sat_add(ff_q, ap_q);
    sat_hit  = (u_raw >= lp) || (u_raw <= -lp);
    same_dir = ((e_q > 0) && (u_raw > 0)) || ((e_q < 0) && (u_raw < 0));
    frz      = sat_hit && same_dir;
    acc_new  = sat_add(fbr_q, t_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_aff_q     <= '0;
      k_vff_q     <= '0;
      fric_q      <= '0;
      k_p_q       <= '0;
      k_i_q       <= '0;
      lim_q       <= ONE_Q;
      beta_q      <= ONE_Q;
      k_bc_q      <= '0;
      traj_q      <= '0;
      pew_q       <= '0;
      acc_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ACCEL_FF: k_aff_q <= cfg_data_i[GW-1:0];
          REG_VEL_FF:   k_vff_q <= cfg_data_i[GW-1:0];
          REG_FRICTION: fric_q  <= $signed(cfg_data_i);
          REG_PROP:     k_p_q   <= cfg_data_i[GW-1:0];
          REG_INTEG:    k_i_q   <= cfg_data_i[GW-1:0];
          REG_LIMIT:    lim_q   <= cfg_data_i[GW-1:0];
          REG_WEIGHT:   beta_q  <= cfg_data_i[GW-1:0];
          REG_BACKCALC: k_bc_q  <= cfg_data_i[GW-1:0];
          default:      k_bc_q  <= k_bc_q;
        endcase
      end
      if (cmd_i.div_go) begin
        traj_q <= sat_add(traj_q, d_q);
      end
      if (cmd_i.op == OP_FINAL) begin
        acc_q  <= acc_new;
        last_q <= clamp_l(sat_add(ff_q, acc_new), lim_q);
        pew_q  <= ew_q;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tgt_q    <= speed_target_i;
      meas_q   <= speed_measured_i;
      per_q    <= step_period_i;
      frozen_q <= 1'b0;
      held_q   <= 1'b0;
    end
    if (mul_done) begin
      case (cmd_i.op)
        OP_STEP: stepmax_q <= mul_res;
        OP_AFF:  aff_q     <= mul_res;
        OP_VFF:  vff_q     <= mul_res;
        OP_BT:   bt_q      <= mul_res;
        OP_P:    p_q       <= mul_res;
        OP_KIE:  kie_q     <= mul_res;
        OP_I:    i_q       <= mul_res;
        OP_BCG:  bc_q      <= mul_res;
        OP_BCT:  t_q       <= mul_res;
        default: t_q       <= t_q;
      endcase
    end
    if (div_done) begin
      accel_q <= div_res;
    end
    case (cmd_i.op)
      OP_HOLD: begin
        ff_q   <= '0;
        held_q <= 1'b1;
      end
      OP_CLAMP: d_q <= d_next;
      OP_FF: begin
        ff_q <= sat_add(sat_add(aff_q, vff_q), fric_q);
        e_q  <= sat_sub(tgt_q, meas_q);
      end
      OP_EW: ew_q <= sat_sub(bt_q, meas_q);
      OP_SUM: begin
        ap_q  <= sat_add(acc_q, p_q);
        fbr_q <= sat_add(sat_add(acc_q, p_q), i_q);
      end
      OP_GATE: begin
        frozen_q <= frz;
        fbr_q    <= frz ? ap_q : fbr_q;
        u_q      <= frz ? u_alt : u_raw;
      end
      OP_LIMD: bcd_q <= sat_sub(clamp_l(u_q, lim_q), u_q);
      default: bcd_q <= bcd_q;
    endcase
    if (cmd_i.push) begin
      torque_q <= last_q;
      ffo_q    <= ff_q;
      fbo_q    <= acc_q;
      frzo_q   <= frozen_q;
      heldo_q  <= held_q;
    end
  end

  assign sts_o.per_zero = (per_q == '0);
  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign torque_out_o       = torque_q;
  assign feedforward_part_o = ffo_q;
  assign feedback_part_o    = fbo_q;
  assign integral_frozen_o  = frzo_q;
  assign held_o             = heldo_q;

endmodule
`default_nettype wire

FILE: rtl/velocity_incremental_pi_loop.sv
// Top level of the forward speed loop: feedforward plus incremental PI control.
//
// One input beat on the s_axis side carries a speed target, a measured speed and
// the tick period; for each one the block returns exactly one result beat on the
// m_axis side with the clamped torque, the feedforward and feedback parts and two
// flags. The user must write gains and limits through the cfg port while the
// block idles; the block itself does not enforce this.
//
// The block works on one tick at a time: nine products go through one serial
// multiplier, which takes its operand in byte digits (four at the defaults), and
// the acceleration comes from a one-bit-per-cycle divider. A zero period skips
// the computation and goes from the start state through the hold state to the
// push state. s_axis_tready is high only while no tick is in progress.
//
// The result sits in an output register; a new input beat is taken while it
// waits. When the receiver stalls with a result still pending, the next tick
// finishes and then waits until the output register frees up.
// Reset clears the loop state to zero, the torque limit and set-point weight
// to 1.0 and the other configuration registers to zero.
`default_nettype none
module velocity_incremental_pi_loop #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [vipl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [DATA_WIDTH-1:0]                cfg_data_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // speed_target, speed_measured, step_period
  input  wire logic [((2*DATA_WIDTH+32+7)/8)*8-1:0] s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // torque_out, feedforward_part, feedback_part
  output logic [((3*DATA_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
  // integral_frozen, held
  output logic [1:0]                                m_axis_tuser
);
  import vipl_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int OUT_W = ((3*DW+7)/8)*8;

  cmd_t cmd;
  sts_t sts;
  logic signed [DW-1:0] torque, ffp, fbp;
  logic frozen, held;

  vipl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vipl_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .speed_target_i     ($signed(s_axis_tdata[DW-1:0])),
    .speed_measured_i   ($signed(s_axis_tdata[2*DW-1:DW])),
    .step_period_i      (s_axis_tdata[2*DW+PERIOD_BITS-1:2*DW]),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .torque_out_o       (torque),
    .feedforward_part_o (ffp),
    .feedback_part_o    (fbp),
    .integral_frozen_o  (frozen),
    .held_o             (held)
  );

  assign m_axis_tdata = OUT_W'({fbp, ffp, torque});
  assign m_axis_tuser = {held, frozen};

endmodule
`default_nettype wire

FILE: rtl/vipl_checker.sv
// Port-level checker for the speed loop and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module vipl_checker #(
  parameter int DATA_WIDTH = 32
) (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 s_axis_tvalid,
  input wire logic                                 s_axis_tready,
  input wire logic                                 m_axis_tvalid,
  input wire logic                                 m_axis_tready,
  input wire logic [((3*DATA_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
  input wire logic [1:0]                           m_axis_tuser
);

  `VIPL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `VIPL_ASSERT_NEXT(a_one_tick, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `VIPL_ASSERT(a_flags_excl, m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
  `VIPL_ASSERT(a_held_noff, (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH] == '0))

endmodule

bind velocity_incremental_pi_loop vipl_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_vipl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
